FILE: hw/rtl/lst_pkg.sv
package lst_pkg;

  localparam int NODE_W    = 9;
  localparam int DEPTH_W   = 9;
  localparam int POS_OUT_W = 10;
  localparam int STATUS_W  = 2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_NODE   = 2'd2;

  // one depth comparison for the shared compare unit
  typedef struct packed {
    logic [DEPTH_W-1:0] left;
    logic [DEPTH_W-1:0] right;
    logic               tie_left;
  } cmp_req_t;

endpackage

FILE: hw/rtl/lca_sparse_table_query.sv
// Lowest-common-ancestor engine over an Euler tour with a sparse range-minimum table.
// Load requests (func 0) write one tour entry each; the entry marked last then builds all
// LEVELS levels through one shared depth comparator and memories with one read and one
// write port each. Query requests (func 1) end early when the table is not built or a node
// was never loaded, and otherwise run through the chain of dependent memory reads.
// After reset, and before the first entry of every new tour, a clearing pass sweeps all
// MAX_NODES entries of the first-position memory; no request is accepted meanwhile.
module lca_sparse_table_query import lst_pkg::*; #(
  parameter int MAX_NODES = 512,
  parameter int TOUR_LEN  = 1024,
  parameter int LEVELS    = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic                 func,
  input  logic [NODE_W-1:0]    node_a,
  input  logic [DEPTH_W-1:0]   node_depth,
  input  logic [NODE_W-1:0]    node_b,
  input  logic                 last,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [POS_OUT_W-1:0] lca_position,
  output logic [NODE_W-1:0]    lca_node,
  output logic [STATUS_W-1:0]  status
);

  localparam int POS_W  = $clog2(TOUR_LEN);
  localparam int CNT_W  = $clog2(TOUR_LEN + 1);
  localparam int NIDX_W = $clog2(MAX_NODES);
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int TBL_AW = $clog2(LEVELS * TOUR_LEN);
  localparam int LZ_W   = $clog2(POS_W);
  localparam int FP_W   = POS_W + 1;
  localparam int TOUR_W = NODE_W + DEPTH_W;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLR    = 5'd1;
  localparam logic [4:0] S_LD_ST  = 5'd2;
  localparam logic [4:0] S_LD_FP  = 5'd3;
  localparam logic [4:0] S_B0_A   = 5'd4;
  localparam logic [4:0] S_B0_B   = 5'd5;
  localparam logic [4:0] S_B0_C   = 5'd6;
  localparam logic [4:0] S_BJ_A   = 5'd7;
  localparam logic [4:0] S_BJ_B   = 5'd8;
  localparam logic [4:0] S_BJ_C   = 5'd9;
  localparam logic [4:0] S_BJ_D   = 5'd10;
  localparam logic [4:0] S_BJ_E   = 5'd11;
  localparam logic [4:0] S_Q_CHK  = 5'd12;
  localparam logic [4:0] S_Q_FA   = 5'd13;
  localparam logic [4:0] S_Q_FB   = 5'd14;
  localparam logic [4:0] S_Q_K    = 5'd15;
  localparam logic [4:0] S_Q_X    = 5'd16;
  localparam logic [4:0] S_Q_Y    = 5'd17;
  localparam logic [4:0] S_Q_DX   = 5'd18;
  localparam logic [4:0] S_Q_DY   = 5'd19;
  localparam logic [4:0] S_Q_W    = 5'd20;
  localparam logic [4:0] S_Q_NODE = 5'd21;
  localparam logic [4:0] S_Q_NFP  = 5'd22;
  localparam logic [4:0] S_Q_OUT  = 5'd23;

  logic [TOUR_W-1:0] tour_mem [TOUR_LEN];
  logic [FP_W-1:0]   fp_mem   [MAX_NODES];
  logic [POS_W-1:0]  tbl_mem  [LEVELS*TOUR_LEN];

  logic [4:0]         state;
  logic [NIDX_W-1:0]  clr_idx;
  logic               pending;
  logic [CNT_W-1:0]   cnt;
  logic               ready_tbl;
  logic               item_func;
  logic [NODE_W-1:0]  item_a;
  logic [NODE_W-1:0]  item_b;
  logic [DEPTH_W-1:0] item_dep;
  logic               item_last;
  logic [POS_W-1:0]   idx;
  logic [LVL_W-1:0]   lvl;
  logic [TBL_AW-1:0]  tbl_base;
  logic [TBL_AW-1:0]  prev_base;
  logic [POS_W-1:0]   left_pos;
  logic [POS_W-1:0]   right_pos;
  logic [DEPTH_W-1:0] dl;
  logic [FP_W-1:0]    fa;
  logic [POS_W-1:0]   p_pos;
  logic [POS_W-1:0]   q_pos;
  logic [LVL_W-1:0]   k_lvl;
  logic [TBL_AW-1:0]  k_base;
  logic [POS_W-1:0]   win;
  logic [NODE_W-1:0]  win_node;

  logic [TOUR_W-1:0] tour_rd, tour_wd;
  logic [POS_W-1:0]  tour_ra, tour_wa;
  logic              tour_we;
  logic [FP_W-1:0]   fp_rd, fp_wd;
  logic [NIDX_W-1:0] fp_ra, fp_wa;
  logic              fp_we;
  logic [POS_W-1:0]  tbl_rd, tbl_wd;
  logic [TBL_AW-1:0] tbl_ra, tbl_wa;
  logic              tbl_we;

  logic [DEPTH_W-1:0] rd_depth;
  logic [NODE_W-1:0]  rd_node;
  logic [POS_W-1:0]   cnt_last;
  logic               store_ok;
  logic               a_in, b_in, rd_node_in;
  logic               span_end;
  logic [POS_W-1:0]   half;
  logic               fp_seen;
  logic [POS_W-1:0]   fp_pos;
  logic [POS_W-1:0]   diff;
  logic [LZ_W-1:0]    msb;
  logic [LVL_W-1:0]   k_sat;
  logic               idx_last;
  logic               accept;
  cmp_req_t           cmp_req;
  logic               take_left;

  assign rd_depth   = tour_rd[DEPTH_W-1:0];
  assign rd_node    = tour_rd[TOUR_W-1:DEPTH_W];
  assign cnt_last   = POS_W'(cnt - CNT_W'(1));
  assign store_ok   = cnt < CNT_W'(TOUR_LEN);
  assign a_in       = 32'(item_a) < MAX_NODES;
  assign b_in       = 32'(item_b) < MAX_NODES;
  assign rd_node_in = 32'(rd_node) < MAX_NODES;
  assign span_end   = (32'(idx) + (32'(1) << lvl)) >= 32'(cnt);
  assign half       = POS_W'(32'(1) << (lvl - LVL_W'(1)));
  assign fp_seen    = fp_rd[FP_W-1];
  assign fp_pos     = fp_rd[POS_W-1:0];
  assign diff       = q_pos - p_pos;
  assign k_sat      = (32'(msb) > LEVELS - 1) ? LVL_W'(LEVELS - 1) : LVL_W'(msb);
  assign idx_last   = idx == cnt_last;
  assign req_stall  = (state != S_IDLE) || (res_valid && res_stall);
  assign accept     = req_valid && !req_stall;

  assign cmp_req.left     = dl;
  assign cmp_req.right    = rd_depth;
  assign cmp_req.tie_left = state == S_BJ_E;

  lst_depth_cmp u_cmp (
    .req       (cmp_req),
    .take_left (take_left)
  );

  lst_lead_one #(.W(POS_W)) u_lead (
    .value (diff),
    .msb   (msb)
  );

  always_comb begin
    tour_ra = '0;
    tour_we = 1'b0;
    tour_wa = POS_W'(cnt);
    tour_wd = {item_a, item_dep};
    fp_ra   = NIDX_W'(item_a);
    fp_we   = 1'b0;
    fp_wa   = NIDX_W'(item_a);
    fp_wd   = {1'b1, POS_W'(cnt)};
    tbl_ra  = '0;
    tbl_we  = 1'b0;
    tbl_wa  = tbl_base + TBL_AW'(idx);
    tbl_wd  = cnt_last;
    unique case (state)
      S_CLR: begin
        fp_we = 1'b1;
        fp_wa = clr_idx;
        fp_wd = '0;
      end
      S_LD_ST: tour_we = store_ok;
      S_LD_FP: fp_we = store_ok && a_in && !fp_seen;
      S_B0_A: begin
        if (idx_last) tbl_we = 1'b1;
        else tour_ra = idx;
      end
      S_B0_B: tour_ra = idx + POS_W'(1);
      S_B0_C: begin
        tbl_we = 1'b1;
        tbl_wd = take_left ? idx : idx + POS_W'(1);
      end
      S_BJ_A: begin
        if (span_end) tbl_we = 1'b1;
        else tbl_ra = prev_base + TBL_AW'(idx);
      end
      S_BJ_B: tbl_ra = prev_base + TBL_AW'(idx) + TBL_AW'(half);
      S_BJ_C: tour_ra = left_pos;
      S_BJ_D: tour_ra = right_pos;
      S_BJ_E: begin
        tbl_we = 1'b1;
        tbl_wd = take_left ? left_pos : right_pos;
      end
      S_Q_FA:   fp_ra = NIDX_W'(item_b);
      S_Q_X:    tbl_ra = k_base + TBL_AW'(p_pos);
      S_Q_Y:    tbl_ra = k_base + TBL_AW'(q_pos - POS_W'(32'(1) << k_lvl));
      S_Q_DX:   tour_ra = left_pos;
      S_Q_DY:   tour_ra = right_pos;
      S_Q_NODE: tour_ra = win;
      S_Q_NFP:  fp_ra = NIDX_W'(rd_node);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    tour_rd <= tour_mem[tour_ra];
    if (tour_we) tour_mem[tour_wa] <= tour_wd;
  end

  always_ff @(posedge clk) begin
    fp_rd <= fp_mem[fp_ra];
    if (fp_we) fp_mem[fp_wa] <= fp_wd;
  end

  always_ff @(posedge clk) begin
    tbl_rd <= tbl_mem[tbl_ra];
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      pending   <= 1'b0;
      cnt       <= '0;
      ready_tbl <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item_func <= func;
            item_a    <= node_a;
            item_b    <= node_b;
            item_dep  <= node_depth;
            item_last <= last;
            if (func == FUNC_QUERY) begin
              state <= S_Q_CHK;
            end else if (ready_tbl) begin
              // new tour: forget the old one before storing
              ready_tbl <= 1'b0;
              cnt       <= '0;
              clr_idx   <= '0;
              pending   <= 1'b1;
              state     <= S_CLR;
            end else begin
              state <= S_LD_ST;
            end
          end
        end
        S_CLR: begin
          clr_idx <= clr_idx + NIDX_W'(1);
          if (clr_idx == NIDX_W'(MAX_NODES - 1)) begin
            pending <= 1'b0;
            state   <= pending ? S_LD_ST : S_IDLE;
          end
        end
        S_LD_ST: state <= S_LD_FP;
        S_LD_FP: begin
          if (store_ok) cnt <= cnt + CNT_W'(1);
          if (item_last) begin
            lvl      <= '0;
            tbl_base <= '0;
            idx      <= '0;
            state    <= S_B0_A;
          end else begin
            state <= S_IDLE;
          end
        end
        S_B0_A, S_BJ_A, S_BJ_E: begin
          if ((state == S_B0_A && idx_last) || (state != S_B0_A && (state == S_BJ_E ||
              span_end) && idx_last)) begin
            // level finished
            if (lvl == LVL_W'(LEVELS - 1)) begin
              ready_tbl <= 1'b1;
              state     <= S_IDLE;
            end else begin
              lvl       <= lvl + LVL_W'(1);
              prev_base <= tbl_base;
              tbl_base  <= tbl_base + TBL_AW'(TOUR_LEN);
              idx       <= '0;
              state     <= S_BJ_A;
            end
          end else if (state == S_B0_A) begin
            state <= S_B0_B;
          end else if (state == S_BJ_E || span_end) begin
            idx   <= idx + POS_W'(1);
            state <= S_BJ_A;
          end else begin
            state <= S_BJ_B;
          end
        end
        S_B0_B: begin
          dl    <= rd_depth;
          state <= S_B0_C;
        end
        S_B0_C: begin
          idx   <= idx + POS_W'(1);
          state <= S_B0_A;
        end
        S_BJ_B: begin
          left_pos <= tbl_rd;
          state    <= S_BJ_C;
        end
        S_BJ_C: begin
          right_pos <= tbl_rd;
          state     <= S_BJ_D;
        end
        S_BJ_D: begin
          dl    <= rd_depth;
          state <= S_BJ_E;
        end
        S_Q_CHK: begin
          if (!ready_tbl || !a_in || !b_in) begin
            res_valid    <= 1'b1;
            lca_position <= '0;
            lca_node     <= '0;
            status       <= ready_tbl ? ST_NO_NODE : ST_NOT_BUILT;
            state        <= S_IDLE;
          end else begin
            state <= S_Q_FA;
          end
        end
        S_Q_FA: begin
          fa    <= fp_rd;
          state <= S_Q_FB;
        end
        S_Q_FB: begin
          if (!fa[FP_W-1] || !fp_seen) begin
            res_valid    <= 1'b1;
            lca_position <= '0;
            lca_node     <= '0;
            status       <= ST_NO_NODE;
            state        <= S_IDLE;
          end else if (fa[POS_W-1:0] == fp_pos) begin
            win   <= fp_pos;
            state <= S_Q_NODE;
          end else begin
            p_pos <= (fa[POS_W-1:0] < fp_pos) ? fa[POS_W-1:0] : fp_pos;
            q_pos <= (fa[POS_W-1:0] < fp_pos) ? fp_pos : fa[POS_W-1:0];
            state <= S_Q_K;
          end
        end
        S_Q_K: begin
          k_lvl  <= k_sat;
          k_base <= TBL_AW'(32'(k_sat) * TOUR_LEN);
          state  <= S_Q_X;
        end
        S_Q_X: state <= S_Q_Y;
        S_Q_Y: begin
          left_pos <= tbl_rd;
          state    <= S_Q_DX;
        end
        S_Q_DX: begin
          right_pos <= tbl_rd;
          state     <= S_Q_DY;
        end
        S_Q_DY: begin
          dl    <= rd_depth;
          state <= S_Q_W;
        end
        S_Q_W: begin
          win   <= take_left ? left_pos : right_pos;
          state <= S_Q_NODE;
        end
        S_Q_NODE: state <= S_Q_NFP;
        S_Q_NFP: begin
          win_node <= rd_node;
          if (rd_node_in) begin
            state <= S_Q_OUT;
          end else begin
            // entry with an out-of-range node reports its own position
            res_valid    <= 1'b1;
            lca_position <= POS_OUT_W'(win);
            lca_node     <= rd_node;
            status       <= ST_OK;
            state        <= S_IDLE;
          end
        end
        S_Q_OUT: begin
          res_valid    <= 1'b1;
          lca_position <= POS_OUT_W'(fp_seen ? fp_pos : win);
          lca_node     <= win_node;
          status       <= ST_OK;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_null_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_OK |-> lca_position == '0 && lca_node == '0)
    else $error("rejected request carries non-zero fields");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TOUR_LEN))
    else $error("entry count past tour length");

  a_ready_at_top: assert property (@(posedge clk) disable iff (rst)
    $rose(ready_tbl) |-> $past(lvl) == LVL_W'(LEVELS - 1))
    else $error("table marked ready before the top level");

  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(item_func) == FUNC_QUERY)
    else $error("result produced by a load");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> req_stall)
    else $error("request taken during clearing pass");

endmodule

FILE: hw/rtl/lst_depth_cmp.sv
module lst_depth_cmp import lst_pkg::*; (
  input  cmp_req_t req,
  output logic     take_left
);

  assign take_left = req.tie_left ? (req.left <= req.right) : (req.left < req.right);

endmodule

FILE: hw/rtl/lst_lead_one.sv
module lst_lead_one #(
  parameter int W = 10
) (
  input  logic [W-1:0]         value,
  output logic [$clog2(W)-1:0] msb
);

  always_comb begin
    msb = '0;
    for (int i = 0; i < W; i++) begin
      if (value[i]) msb = ($clog2(W))'(i);
    end
  end

endmodule
